[src/regex_dot_star_matcher_unit_macros.svh]
// assertion helpers for the regex matcher
`ifndef REGEX_DOT_STAR_MATCHER_UNIT_MACROS_SVH
`define REGEX_DOT_STAR_MATCHER_UNIT_MACROS_SVH

// expression must hold at every clock edge outside reset
`define RDSM_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define RDSM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define RDSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/rdsm_pkg.sv]
package rdsm_pkg;

  localparam logic [7:0] SYM_STAR  = 8'd42;
  localparam logic [7:0] SYM_DOT   = 8'd46;
  localparam logic [7:0] SYM_SPACE = 8'd32;

  typedef enum logic [1:0] {
    MODE_CLEAR   = 2'd0,
    MODE_APPEND  = 2'd1,
    MODE_RESTART = 2'd2,
    MODE_TEXT    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_WAVE   = 2'd1,
    ST_FINISH = 2'd2
  } state_t;

  // per-transaction control shared by all cells
  typedef struct packed {
    logic       rebuild;
    logic [7:0] sym;
  } ctl_t;

  // what a cell hands to its right-hand neighbors
  typedef struct packed {
    logic tok;
    logic old_b;
    logic cur_b;
  } cell_link_t;

endpackage

[src/rdsm_cell.sv]
module rdsm_cell (
  input  logic                   clk,
  input  logic                   rst_n,
  input  rdsm_pkg::ctl_t         ctl,
  input  logic                   en,
  input  logic                   wr_en,
  input  logic [7:0]             wr_chr,
  input  rdsm_pkg::cell_link_t   prev_link,
  input  logic                   two_back_b,
  input  logic [7:0]             pre_chr,
  output rdsm_pkg::cell_link_t   link,
  output logic [7:0]             chr,
  output logic                   go
);
  import rdsm_pkg::*;

  logic       tok_r;
  logic       bit_r;
  logic       bit_nxt;
  logic       old_r;
  logic [7:0] chr_r;
  logic       is_star;
  logic       is_dot;
  logic       pre_hit;

  assign go      = prev_link.tok & en;
  assign is_star = (chr_r == SYM_STAR);
  assign is_dot  = (chr_r == SYM_DOT);
  assign pre_hit = (pre_chr == ctl.sym) || (pre_chr == SYM_DOT);

  always_comb begin
    bit_nxt = 1'b0;
    if (ctl.rebuild) begin
      bit_nxt = is_star & two_back_b;
    end else if (is_dot) begin
      bit_nxt = prev_link.old_b;
    end else if (is_star) begin
      bit_nxt = two_back_b | (pre_hit & bit_r);
    end else if (chr_r == ctl.sym) begin
      bit_nxt = prev_link.old_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
      bit_r <= 1'b0;
    end else begin
      tok_r <= go;
      if (go) begin
        bit_r <= bit_nxt;
      end
    end
  end

  // previous row bit, consumed by the right neighbor in the next cycle
  always_ff @(posedge clk) begin
    if (go) begin
      old_r <= bit_r;
    end
    if (wr_en) begin
      chr_r <= wr_chr;
    end
  end

  assign link.tok   = tok_r;
  assign link.old_b = old_r;
  assign link.cur_b = bit_r;
  assign chr        = chr_r;

endmodule

[src/regex_dot_star_matcher_unit.sv]
// regex_dot_star_matcher_unit
// whole-string matcher for patterns of literals, '.' and 'x*'
// input channel: in_valid/in_ready with in_mode and in_symbol
//   clear pattern, append a pattern character, restart text, or one text byte
// result channel: out_valid/out_ready with out_matched and out_pattern_overflow,
//   exactly one result transaction per input transaction, in order
// the pattern lives in a chain of PATTERN_MAX cells, one character each; a
// token walks the chain one cell per cycle rebuilding or advancing the match row
// after accept the token walks the L cells of the pattern (L = pattern length after
//   the transaction; none for clear or a dropped append), then the result is loaded;
//   one transaction is in work at a time, so no new one is taken until it is done
// the finished result sits in an output register, so a new transaction is taken
//   while it still waits; a stalled receiver only holds the block in its final
//   step when a second result is ready before the first is taken
// reset (rst_n low, synchronous): empty pattern, row with bit zero set, no
//   result pending; pattern characters are not cleared
module regex_dot_star_matcher_unit #(
  parameter int PATTERN_MAX = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_mode,
  input  logic [7:0] in_symbol,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_matched,
  output logic       out_pattern_overflow
);
  import rdsm_pkg::*;

`include "regex_dot_star_matcher_unit_macros.svh"

  localparam int LEN_W = $clog2(PATTERN_MAX + 1);

  state_t           state_r, state_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             row0_r, row0_nxt;
  logic             row0_old_r;
  logic             start_r, start_nxt;
  logic             ovf_r, ovf_nxt;
  ctl_t             ctl_r;
  logic             out_valid_r, out_valid_nxt;
  logic             out_matched_r;
  logic             out_ovf_r;

  logic             in_fire;
  logic             full;
  logic             load_out;
  logic             done;
  mode_t            mode;

  cell_link_t       lk [0:PATTERN_MAX];
  logic [7:0]       chr_v [0:PATTERN_MAX];
  logic [PATTERN_MAX:0] go_v;
  logic [PATTERN_MAX:0] row_v;

  assign mode    = mode_t'(in_mode);
  assign in_fire = in_valid & in_ready;
  assign full    = (len_r == LEN_W'(PATTERN_MAX));
  assign done    = go_v[len_r];

  // column zero of the row lives here, ahead of the first cell
  assign lk[0].tok   = start_r;
  assign lk[0].old_b = row0_old_r;
  assign lk[0].cur_b = row0_r;
  assign chr_v[0]    = SYM_SPACE;   // leading star compares against a space
  assign go_v[0]     = 1'b0;
  assign row_v[0]    = row0_r;

  genvar j;
  generate
    for (j = 1; j <= PATTERN_MAX; j++) begin : g_cell
      logic two_back;
      if (j >= 2) begin : g_two
        assign two_back = lk[j-2].cur_b;
      end else begin : g_one
        assign two_back = 1'b0;
      end

      rdsm_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl_r),
        .en         (len_r >= LEN_W'(j)),
        .wr_en      (in_fire && (mode == MODE_APPEND) && !full && (len_r == LEN_W'(j - 1))),
        .wr_chr     (in_symbol),
        .prev_link  (lk[j-1]),
        .two_back_b (two_back),
        .pre_chr    (chr_v[j-1]),
        .link       (lk[j]),
        .chr        (chr_v[j]),
        .go         (go_v[j])
      );

      assign row_v[j] = lk[j].cur_b;
    end
  endgenerate

  // transaction decode: pattern length, column zero, overflow flag and wave launch
  always_comb begin
    len_nxt   = len_r;
    row0_nxt  = row0_r;
    start_nxt = 1'b0;
    ovf_nxt   = ovf_r;
    if (in_fire) begin
      ovf_nxt = 1'b0;
      case (mode)
        MODE_CLEAR: begin
          len_nxt  = '0;
          row0_nxt = 1'b1;
        end
        MODE_APPEND: begin
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            len_nxt   = len_r + LEN_W'(1);
            row0_nxt  = 1'b1;
            start_nxt = 1'b1;
          end
        end
        MODE_RESTART: begin
          row0_nxt  = 1'b1;
          start_nxt = (len_r != '0);
        end
        MODE_TEXT: begin
          row0_nxt  = 1'b0;
          start_nxt = (len_r != '0);
        end
        default: begin
          row0_nxt = row0_r;
        end
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = start_nxt ? ST_WAVE : ST_FINISH;
        end
      end
      ST_WAVE: begin
        if (done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // outputs of the state machine
  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    case (state_r)
      ST_IDLE:   in_ready = 1'b1;
      ST_WAVE:   load_out = 1'b0;
      ST_FINISH: load_out = !out_valid_r || out_ready;
      default:   in_ready = 1'b0;
    endcase
  end

  assign out_valid_nxt = load_out | (out_valid_r & ~out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= '0;
      row0_r      <= 1'b1;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      row0_r      <= row0_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload side, no reset needed
  always_ff @(posedge clk) begin
    ovf_r <= ovf_nxt;
    if (in_fire) begin
      row0_old_r    <= row0_r;
      ctl_r.rebuild <= (mode != MODE_TEXT);
      ctl_r.sym     <= in_symbol;
    end
    if (load_out) begin
      out_matched_r <= row_v[len_r];
      out_ovf_r     <= ovf_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_matched          = out_matched_r;
  assign out_pattern_overflow = out_ovf_r;

  // at most one cell active, the wave is a single token
  `RDSM_ASSERT_ALWAYS(a_one_token, $onehot0(go_v), "more than one cell active")
  // nothing in flight in the chain while taking a new transaction
  `RDSM_ASSERT_IMPL(a_idle_quiet, in_ready, !start_r && (go_v == '0), "wave in flight at accept")
  // an overflow result only comes from a full pattern store
  `RDSM_ASSERT_IMPL(a_ovf_full, load_out && ovf_r,
                    len_r == LEN_W'(PATTERN_MAX), "overflow with room in store")
  // a text byte always clears column zero
  `RDSM_ASSERT_NEXT(a_text_row0, in_fire && (mode == MODE_TEXT), !row0_r,
                    "column zero set after text byte")

endmodule

[test/tb_top.sv]
module tb_top;
  import rdsm_pkg::*;

  // depth of the pattern store in the block under test (its default)
  localparam int PMAX = 32;
  // hard ceiling on run length, in clock cycles
  localparam int CYCLE_LIMIT = 400000;
  // items per idling phase, four phases in all
  localparam int PHASE_ITEMS = 100;
  // cycles allowed after the last result: longest token walk plus margin
  localparam int TAIL_CYCLES = PMAX + 10;

  localparam logic [7:0] CH_A = "a";
  localparam logic [7:0] CH_B = "b";

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_mode = MODE_CLEAR;
  logic [7:0] in_symbol = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_matched;
  logic       out_pattern_overflow;

  // idling percentages for the current phase
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned items_sent = 0;

  // keeps its own copy of the pattern and the match row, and the queue of
  // verdicts still owed by the block
  class match_scoreboard;
    typedef struct packed {
      logic matched;
      logic overflow;
    } verdict_t;

    logic [7:0]  pat_chars [PMAX];
    int unsigned pat_len;
    logic [PMAX:0] match_bits;
    verdict_t    verdict_q [$];
    int unsigned errors;

    function new();
      pat_len = 0;
      match_bits = '0;
      match_bits[0] = 1'b1;
      errors = 0;
      foreach (pat_chars[i]) pat_chars[i] = 8'd0;
    endfunction

    // empty text: only star pairs can be skipped
    function void reset_row();
      logic [PMAX:0] r;
      r = '0;
      r[0] = 1'b1;
      for (int j = 1; j <= pat_len; j++)
        if (pat_chars[j-1] == SYM_STAR && j >= 2 && r[j-2]) r[j] = 1'b1;
      match_bits = r;
    endfunction

    function void consume_byte(logic [7:0] c);
      logic [PMAX:0] prev;
      logic [PMAX:0] r;
      logic [7:0]    pc;
      logic [7:0]    lead;
      logic          b;
      prev = match_bits;
      r = '0;
      for (int j = 1; j <= pat_len; j++) begin
        pc = pat_chars[j-1];
        b = 1'b0;
        if (pc == SYM_DOT) begin
          b = prev[j-1];
        end else if (pc == SYM_STAR) begin
          // a star with nothing before it repeats a space
          lead = (j >= 2) ? pat_chars[j-2] : SYM_SPACE;
          if (j >= 2) b = r[j-2];
          if (lead == c || lead == SYM_DOT) b = b | prev[j];
        end else if (pc == c) begin
          b = prev[j-1];
        end
        r[j] = b;
      end
      match_bits = r;
    endfunction

    function void note_transaction(mode_t m, logic [7:0] s);
      verdict_t v;
      v.overflow = 1'b0;
      case (m)
        MODE_CLEAR: begin
          pat_len = 0;
          reset_row();
        end
        MODE_APPEND: begin
          if (pat_len < PMAX) begin
            pat_chars[pat_len] = s;
            pat_len++;
            reset_row();
          end else begin
            v.overflow = 1'b1;
          end
        end
        MODE_RESTART: reset_row();
        default: consume_byte(s);
      endcase
      v.matched = match_bits[pat_len];
      verdict_q.push_back(v);
    endfunction

    function void check_result(logic m, logic o);
      verdict_t v;
      if (verdict_q.size() == 0) begin
        $error("unexpected result transaction: matched=%0b pattern_overflow=%0b", m, o);
        errors++;
        return;
      end
      v = verdict_q.pop_front();
      if (m !== v.matched) begin
        $error("matched: expected %0b, got %0b", v.matched, m);
        errors++;
      end
      if (o !== v.overflow) begin
        $error("pattern_overflow: expected %0b, got %0b", v.overflow, o);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return verdict_q.size();
    endfunction
  endclass

  match_scoreboard sb = new();

  regex_dot_star_matcher_unit #(
    .PATTERN_MAX(PMAX)
  ) u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_mode              (in_mode),
    .in_symbol            (in_symbol),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_matched          (out_matched),
    .out_pattern_overflow (out_pattern_overflow)
  );

  // period of two time units
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver: stall at random according to the phase
  always @(posedge clk) begin
    out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  // both monitors sample at the edge, before any register update is visible;
  // the input side is noted first so the queue order stays oldest first
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_transaction(mode_t'(in_mode), in_symbol);
    if (rst_n && out_valid && out_ready) sb.check_result(out_matched, out_pattern_overflow);
  end

  // watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb_top: errors");
    $finish;
  end

  // one input transaction; valid is only lowered when a gap is taken, so a
  // back-to-back item never sees valid dropped and raised in one step
  task automatic send_item(mode_t m, logic [7:0] s);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid  <= 1'b1;
    in_mode   <= m;
    in_symbol <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // hold the sender off until every verdict has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // mostly literals and metacharacters so that matches actually happen
  function automatic logic [7:0] pick_pattern_char();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 30) return CH_A;
    if (r < 50) return CH_B;
    if (r < 70) return SYM_DOT;
    if (r < 88) return SYM_STAR;
    return 8'($urandom);
  endfunction

  // clear (most of the time), load a pattern, restart, then stream text derived
  // from the pattern (so it often matches), sometimes corrupted; fill_store picks
  // a pattern of 30 to 35 characters, which often fills the store
  task automatic run_pattern_sequence(bit fill_store);
    logic [7:0]  pat [$];
    logic [7:0]  txt [$];
    int          n_pat;
    int          reps;
    int unsigned idx;
    bit          fresh;
    fresh = fill_store || ($urandom_range(99) < 85);
    if (fresh) send_item(MODE_CLEAR, 8'($urandom));
    n_pat = fill_store ? $urandom_range(30, 35) : $urandom_range(1, 6);
    for (int i = 0; i < n_pat; i++) begin
      pat.push_back(pick_pattern_char());
      send_item(MODE_APPEND, pat[i]);
    end
    send_item(MODE_RESTART, 8'($urandom));

    for (int i = 0; i < pat.size() && i < PMAX; i++) begin
      if (i + 1 < pat.size() && pat[i+1] == SYM_STAR) begin
        reps = $urandom_range(0, 3);
        repeat (reps) txt.push_back(pat[i] == SYM_DOT ? 8'($urandom) : pat[i]);
        i++;
      end else if (pat[i] == SYM_DOT) begin
        txt.push_back(8'($urandom));
      end else if (pat[i] != SYM_STAR) begin
        txt.push_back(pat[i]);
      end
    end

    // corrupt some of the texts: replace, insert or drop one byte
    if ($urandom_range(99) < 30) begin
      idx = (txt.size() == 0) ? 0 : $urandom_range(txt.size() - 1);
      case ($urandom_range(2))
        0: if (txt.size() != 0) txt[idx] = ($urandom_range(1) != 0) ? CH_A : 8'($urandom);
        1: txt.insert(idx, ($urandom_range(1) != 0) ? CH_B : 8'($urandom));
        default: if (txt.size() != 0) txt.delete(idx);
      endcase
    end

    foreach (txt[k]) begin
      if ($urandom_range(99) < 5) send_item(MODE_RESTART, 8'($urandom));
      send_item(MODE_TEXT, txt[k]);
    end

    if ($urandom_range(99) < 8) drain();
  endtask

  initial begin
    int unsigned target;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty pattern, leading star, symbol extremes, dot and star
    send_item(MODE_TEXT, 8'h00);
    send_item(MODE_RESTART, 8'hFF);
    send_item(MODE_APPEND, SYM_STAR);
    send_item(MODE_TEXT, SYM_SPACE);
    send_item(MODE_CLEAR, 8'hFF);
    send_item(MODE_APPEND, CH_A);
    send_item(MODE_APPEND, SYM_STAR);
    send_item(MODE_APPEND, SYM_DOT);
    send_item(MODE_APPEND, 8'hFF);
    send_item(MODE_TEXT, CH_A);
    send_item(MODE_TEXT, CH_A);
    send_item(MODE_TEXT, "x");
    send_item(MODE_TEXT, 8'hFF);
    send_item(MODE_TEXT, 8'h00);
    send_item(MODE_RESTART, 8'h00);
    send_item(MODE_TEXT, "z");
    send_item(MODE_TEXT, 8'hFF);
    send_item(MODE_CLEAR, 8'h00);
    send_item(MODE_APPEND, SYM_DOT);
    send_item(MODE_APPEND, SYM_STAR);
    send_item(MODE_TEXT, "q");
    send_item(MODE_TEXT, 8'h00);
    drain();

    // random: four idling phases, the first sequence of each aims to fill the store
    target = items_sent;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      target += PHASE_ITEMS;
      run_pattern_sequence(1'b1);
      while (items_sent < target) run_pattern_sequence(1'b0);
      drain();
    end

    recv_stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/rdsm_pkg.sv
src/rdsm_cell.sv
src/regex_dot_star_matcher_unit.sv
test/tb_top.sv
